FILE: sv/tdt_pkg.sv
// ----------------------------------------------------------------------------
// Tile dictionary package
// Types, constants and the default-tile function used by the tile
// dictionary core.
// ----------------------------------------------------------------------------
package tdt_pkg;

    localparam int ENTRIES_DEF  = 256;
    localparam int PLANE_W      = 64;
    localparam int TILE_W       = 2 * PLANE_W;
    localparam int SLOT_W       = 8;
    localparam int NUM_DEFAULTS = 5;

    localparam logic [PLANE_W-1:0] PLANE_ZERO = '0;
    localparam logic [PLANE_W-1:0] PLANE_ONES = '1;

    // Function codes of a command.
    localparam logic FUNC_INSERT = 1'b0;
    localparam logic FUNC_READ   = 1'b1;

    typedef struct packed {
        logic               func;
        logic [PLANE_W-1:0] tile_low;
        logic [PLANE_W-1:0] tile_high;
        logic [SLOT_W-1:0]  read_index;
    } tdt_in_t;

    typedef struct packed {
        logic [SLOT_W-1:0]  slot_index;
        logic               matched;
        logic               table_full;
        logic [PLANE_W-1:0] data_low;
        logic [PLANE_W-1:0] data_high;
        logic               entry_valid;
    } tdt_out_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_RD_ISSUE,
        ST_RD_DATA
    } tdt_state_t;

    // Preloaded tiles of the first entries. Plane 1 sits in the upper half.
    function automatic logic [TILE_W-1:0] default_tile(input logic [2:0] idx);
        logic [TILE_W-1:0] tile;
        case (idx)
            3'd2:    tile = {PLANE_ZERO, PLANE_ONES};
            3'd3:    tile = {PLANE_ONES, PLANE_ZERO};
            3'd4:    tile = {PLANE_ONES, PLANE_ONES};
            default: tile = {PLANE_ZERO, PLANE_ZERO};
        endcase
        return tile;
    endfunction

endpackage

FILE: sv/tdt_ram.sv
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port; the read data is registered.
// ----------------------------------------------------------------------------
module tdt_ram #(
    parameter int WIDTH = 128,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

FILE: sv/tile_dedup_table_core.sv
// ----------------------------------------------------------------------------
// Tile dictionary core
// Deduplicating dictionary of 128-bit tile patterns with find-or-insert and
// read commands.
// ----------------------------------------------------------------------------
// A command is transferred when start is high and busy is low; the block then
// raises busy until the command is finished and shows the one result on the
// result port, marked by done for exactly one cycle. The receiver cannot stall
// that transfer, so it must take the result in the cycle done is high. An
// insert compares the tile against the filled entries from index 1 upward
// with a single 128-bit comparator fed from the default-tile logic and the
// table RAM, one entry per cycle; it ends at the first match, or after the
// last filled entry with a miss, which writes the tile as a new entry if the
// table has room and else reports table_full. A read passes through an issue
// state and a data state, the latter waiting for the registered read port of
// the RAM, before done is raised. Busy drops at the same edge that raises
// done, so the next command can be transferred while the result is shown.
// Entries are filled in order, so a fill count tells which entries hold data;
// entries 0 to 4 hold fixed default tiles generated in logic, so the RAM
// needs no clearing pass and the block accepts commands right after reset.
// ----------------------------------------------------------------------------
module tile_dedup_table_core
    import tdt_pkg::*;
#(
    parameter int ENTRIES = ENTRIES_DEF
) (
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    input  tdt_in_t  cmd,
    output logic     busy,
    output logic     done,
    output tdt_out_t result
);

    localparam int IDX_W = $clog2(ENTRIES);
    localparam int CNT_W = $clog2(ENTRIES + 1);
    localparam int CMP_W = (CNT_W > SLOT_W) ? CNT_W : SLOT_W;

    localparam logic [CNT_W-1:0] CNT_FULL     = CNT_W'(ENTRIES);
    localparam logic [CNT_W-1:0] CNT_DEFAULTS = CNT_W'(NUM_DEFAULTS);

    tdt_state_t        state_reg, state_next;
    tdt_in_t           cmd_reg, cmd_next;
    logic [CNT_W-1:0]  addr_reg, addr_next;
    logic [CNT_W-1:0]  next_free_reg, next_free_next;
    logic              cmp_vld_reg, cmp_vld_next;
    logic [CNT_W-1:0]  data_idx_reg, data_idx_next;
    logic              done_reg, done_next;
    tdt_out_t          result_reg, result_next;

    logic              ram_we;
    logic              ram_re;
    logic [IDX_W-1:0]  ram_raddr;
    logic [TILE_W-1:0] ram_rdata;
    logic [TILE_W-1:0] entry_data;
    logic              tile_equal;
    logic              read_in_range;

    tdt_ram #(
        .WIDTH (TILE_W),
        .DEPTH (ENTRIES)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (next_free_reg[IDX_W-1:0]),
        .wdata ({cmd_reg.tile_high, cmd_reg.tile_low}),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // The default entries come from logic; every other entry from the RAM.
    always_comb
    begin
        if (data_idx_reg < CNT_DEFAULTS)
        begin
            entry_data = default_tile(data_idx_reg[2:0]);
        end
        else
        begin
            entry_data = ram_rdata;
        end
    end

    // The one shared comparator of the search.
    assign tile_equal = (entry_data == {cmd_reg.tile_high, cmd_reg.tile_low});

    // Filled entries are exactly those below the fill count.
    assign read_in_range = (CMP_W'(cmd_reg.read_index) < CMP_W'(next_free_reg));

    always_comb
    begin
        state_next     = state_reg;
        cmd_next       = cmd_reg;
        addr_next      = addr_reg;
        next_free_next = next_free_reg;
        cmp_vld_next   = 1'b0;
        data_idx_next  = data_idx_reg;
        done_next      = 1'b0;
        result_next    = result_reg;
        ram_we         = 1'b0;
        ram_re         = 1'b0;
        ram_raddr      = addr_reg[IDX_W-1:0];

        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd_next  = cmd;
                    addr_next = CNT_W'(1);
                    if (cmd.func == FUNC_READ)
                    begin
                        state_next = ST_RD_ISSUE;
                    end
                    else
                    begin
                        state_next = ST_SCAN;
                    end
                end
            end

            ST_SCAN:
            begin
                // Issue the next filled entry while the previous one compares.
                if (addr_reg != next_free_reg)
                begin
                    ram_re        = 1'b1;
                    addr_next     = addr_reg + CNT_W'(1);
                    data_idx_next = addr_reg;
                    cmp_vld_next  = 1'b1;
                end

                if (cmp_vld_reg && tile_equal)
                begin
                    state_next  = ST_IDLE;
                    done_next   = 1'b1;
                    result_next = '0;
                    result_next.slot_index = SLOT_W'(data_idx_reg);
                    result_next.matched    = 1'b1;
                    cmp_vld_next = 1'b0;
                end
                else if (!cmp_vld_reg && addr_reg == next_free_reg)
                begin
                    // No filled entry matched: append the tile if there is room.
                    state_next  = ST_IDLE;
                    done_next   = 1'b1;
                    result_next = '0;
                    if (next_free_reg != CNT_FULL)
                    begin
                        ram_we = 1'b1;
                        result_next.slot_index = SLOT_W'(next_free_reg);
                        next_free_next = next_free_reg + CNT_W'(1);
                    end
                    else
                    begin
                        result_next.table_full = 1'b1;
                    end
                end
            end

            ST_RD_ISSUE:
            begin
                ram_re        = 1'b1;
                ram_raddr     = IDX_W'(cmd_reg.read_index);
                data_idx_next = CNT_W'(cmd_reg.read_index);
                state_next    = ST_RD_DATA;
            end

            ST_RD_DATA:
            begin
                state_next  = ST_IDLE;
                done_next   = 1'b1;
                result_next = '0;
                result_next.slot_index = cmd_reg.read_index;
                if (read_in_range)
                begin
                    result_next.data_low    = entry_data[PLANE_W-1:0];
                    result_next.data_high   = entry_data[TILE_W-1:PLANE_W];
                    result_next.entry_valid = 1'b1;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            next_free_reg <= CNT_DEFAULTS;
            cmp_vld_reg   <= 1'b0;
            done_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            next_free_reg <= next_free_next;
            cmp_vld_reg   <= cmp_vld_next;
            done_reg      <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg      <= cmd_next;
        addr_reg     <= addr_next;
        data_idx_reg <= data_idx_next;
        result_reg   <= result_next;
    end

    assign busy   = (state_reg != ST_IDLE);
    assign done   = done_reg;
    assign result = result_reg;

endmodule
